### sv/mpsm_pkg.sv
// ----------------------------------------------------------------------------
// mpsm_pkg
// Types, constants and helpers shared by the multi-pattern matcher modules.
// ----------------------------------------------------------------------------
package mpsm_pkg;

  // Automaton sizing
  localparam int unsigned NODE_COUNT    = 128;
  localparam int unsigned ALPHABET_SIZE = 128;
  localparam int unsigned MAX_CHAIN     = 16;
  localparam int unsigned RESULT_LIMIT  = 16;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Fixed field widths
  localparam int unsigned ID_W   = 7;
  localparam int unsigned TAG_W  = 8;
  localparam int unsigned FUNC_W = 2;

  // Derived widths
  localparam int unsigned NODE_W   = $clog2(NODE_COUNT);
  localparam int unsigned TT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int unsigned TT_AW    = $clog2(TT_DEPTH);
  localparam int unsigned VIS_W    = $clog2(MAX_CHAIN + 1);
  localparam int unsigned CNT_W    = $clog2(RESULT_LIMIT + 1);
  localparam int unsigned QP_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QC_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WR_TRANS = 2'd0,
    FUNC_WR_NODE  = 2'd1,
    FUNC_MATCH    = 2'd2,
    FUNC_RESTART  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_WR_TRANS = 3'd1,
    OP_WR_NODE  = 3'd2,
    OP_MATCH    = 3'd3,
    OP_RESTART  = 3'd4
  } op_e;

  typedef struct packed {
    func_e             func;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   symbol;
    logic [ID_W-1:0]   next_node;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   output_link;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  pattern_tag;
    logic [ID_W-1:0]   match_node;
    logic              is_last;
  } out_item_t;

  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   symbol;
    logic [ID_W-1:0]   next_node;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   output_link;
  } cmd_t;

  function automatic logic node_ok(logic [ID_W-1:0] n);
    return (32'(n) < NODE_COUNT);
  endfunction

  function automatic logic sym_ok(logic [ID_W-1:0] s);
    return (32'(s) < ALPHABET_SIZE);
  endfunction

  // Out-of-range stored node falls back to the root
  function automatic logic [NODE_W-1:0] clamp_node(logic [ID_W-1:0] n);
    return node_ok(n) ? NODE_W'(n) : '0;
  endfunction

  function automatic logic [TT_AW-1:0] tt_addr(logic [NODE_W-1:0] n,
                                               logic [ID_W-1:0] s);
    return TT_AW'(32'(n) * ALPHABET_SIZE + 32'(s));
  endfunction

endpackage

### sv/mpsm_front.sv
// ----------------------------------------------------------------------------
// mpsm_front
// Accepts input transactions, decodes the function code and range-checks the
// addresses, and pushes one command per transaction into the queue.
// ----------------------------------------------------------------------------
module mpsm_front import mpsm_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     push_o,
  output cmd_t     cmd_o,
  input  logic     full_i
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.node        = in_item_i.node;
    cmd_o.symbol      = in_item_i.symbol;
    cmd_o.next_node   = in_item_i.next_node;
    cmd_o.tag         = in_item_i.tag;
    cmd_o.output_link = in_item_i.output_link;
    unique case (in_item_i.func)
      FUNC_WR_TRANS: begin
        cmd_o.op = (node_ok(in_item_i.node) && sym_ok(in_item_i.symbol)) ?
                   OP_WR_TRANS : OP_NOP;
      end
      FUNC_WR_NODE: begin
        cmd_o.op = node_ok(in_item_i.node) ? OP_WR_NODE : OP_NOP;
      end
      FUNC_MATCH: begin
        // unknown symbol sends the automaton home
        cmd_o.op = sym_ok(in_item_i.symbol) ? OP_MATCH : OP_RESTART;
      end
      FUNC_RESTART: begin
        cmd_o.op = OP_RESTART;
      end
      default: begin
        cmd_o.op = OP_NOP;
      end
    endcase
  end

endmodule

### sv/mpsm_queue.sv
// ----------------------------------------------------------------------------
// mpsm_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mpsm_queue import mpsm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [QP_W-1:0] ptr_inc(logic [QP_W-1:0] p);
    return (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + QP_W'(1);
  endfunction

  assign full_o  = (32'(cnt_q) == QUEUE_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QC_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### sv/mpsm_back.sv
// ----------------------------------------------------------------------------
// mpsm_back
// Executes queued commands: table writes, restart, and symbol matches with
// the output-link chain walk. Holds the transition and node memories and the
// result output register.
// ----------------------------------------------------------------------------
module mpsm_back import mpsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_STEP  = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Memories
  logic [ID_W-1:0]       tt_mem [TT_DEPTH];
  logic [ID_W-1:0]       tt_rdata_q;
  logic [TT_AW-1:0]      tt_raddr, tt_waddr;
  logic                  tt_we;
  logic [TAG_W+ID_W-1:0] nd_mem [NODE_COUNT];
  logic [TAG_W+ID_W-1:0] nd_rdata_q;
  logic [NODE_W-1:0]     nd_raddr, nd_waddr;
  logic                  nd_we;

  // Walk state
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] walk_q, walk_d;
  logic [VIS_W-1:0]  vis_q, vis_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [TAG_W-1:0]  pend_tag_q, pend_tag_d;
  logic [NODE_W-1:0] pend_node_q, pend_node_d;

  // Output register
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      emit;
  out_item_t emit_item;
  logic      out_free;

  // Walk step decode
  logic [TAG_W-1:0]  wk_tag;
  logic [NODE_W-1:0] wk_link;
  logic              wk_tagged;
  logic [VIS_W-1:0]  wk_vis;
  logic [CNT_W-1:0]  wk_cnt;
  logic              wk_more;
  logic [NODE_W-1:0] step_node;

  assign out_free  = !out_valid_q || out_ready_i;
  assign wk_tag    = nd_rdata_q[TAG_W+ID_W-1:ID_W];
  assign wk_link   = clamp_node(nd_rdata_q[ID_W-1:0]);
  assign wk_tagged = (wk_tag != '0);
  assign wk_vis    = vis_q + VIS_W'(1);
  assign wk_cnt    = cnt_q + CNT_W'(wk_tagged);
  assign wk_more   = (32'(wk_vis) < MAX_CHAIN) && (wk_link != '0) &&
                     (32'(wk_cnt) < RESULT_LIMIT);
  assign step_node = clamp_node(tt_rdata_q);

  assign tt_raddr = tt_addr(cur_q, q_cmd_i.symbol);
  assign tt_waddr = tt_addr(NODE_W'(q_cmd_i.node), q_cmd_i.symbol);
  assign nd_waddr = NODE_W'(q_cmd_i.node);

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    walk_d       = walk_q;
    vis_d        = vis_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_tag_d   = pend_tag_q;
    pend_node_d  = pend_node_q;
    q_pop_o      = 1'b0;
    tt_we        = 1'b0;
    nd_we        = 1'b0;
    nd_raddr     = walk_q;
    emit         = 1'b0;
    emit_item.pattern_tag = pend_tag_q;
    emit_item.match_node  = ID_W'(pend_node_q);
    emit_item.is_last     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_WR_TRANS: tt_we = 1'b1;
            OP_WR_NODE:  nd_we = 1'b1;
            OP_RESTART:  cur_d = '0;
            OP_MATCH:    state_d = S_STEP;
            default: ;
          endcase
        end
      end
      S_STEP: begin
        cur_d    = step_node;
        walk_d   = step_node;
        vis_d    = '0;
        cnt_d    = '0;
        nd_raddr = step_node;
        state_d  = (step_node == '0) ? S_IDLE : S_WALK;
      end
      S_WALK: begin
        // hold the step while a new tag meets a pending result that cannot leave
        if (!(wk_tagged && pend_valid_q && !out_free)) begin
          if (wk_tagged) begin
            emit         = pend_valid_q;
            pend_valid_d = 1'b1;
            pend_tag_d   = wk_tag;
            pend_node_d  = walk_q;
          end
          vis_d  = wk_vis;
          cnt_d  = wk_cnt;
          walk_d = wk_link;
          if (wk_more) begin
            nd_raddr = wk_link;
          end else begin
            state_d = (wk_tagged || pend_valid_q) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_item.is_last     = 1'b1;
          pend_valid_d          = 1'b0;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      walk_q       <= '0;
      vis_q        <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cur_q        <= cur_d;
      walk_q       <= walk_d;
      vis_q        <= vis_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tag_q  <= pend_tag_d;
    pend_node_q <= pend_node_d;
    if (emit) begin
      out_item_q <= emit_item;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tt_we) begin
      tt_mem[tt_waddr] <= q_cmd_i.next_node;
    end
    tt_rdata_q <= tt_mem[tt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (nd_we) begin
      nd_mem[nd_waddr] <= {q_cmd_i.tag, q_cmd_i.output_link};
    end
    nd_rdata_q <= nd_mem[nd_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/multi_pattern_string_matcher_core.sv
// ----------------------------------------------------------------------------
// multi_pattern_string_matcher_core
// Streaming Aho-Corasick matcher over software-loaded automaton tables.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_item_i  (func, node, ...)
//  out     | output    | out_valid_o/out_ready_i| out_item_o (tag, node, last)
//
//  Table writes, restart and dropped writes are done in the back end's idle state.
//  A symbol reads the transition table (S_IDLE, S_STEP), walks the chain
//  (S_WALK), flushing the last result (S_FLUSH) if anything matched; when
//  not held, the walk reads one node a cycle from the single node-memory port.
//  The walk holds while a new tag meets a pending result the output cannot take.
//  Reset clears control state only; table memories stay unknown until written.
// ----------------------------------------------------------------------------
module multi_pattern_string_matcher_core import mpsm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic push, full, q_valid, q_pop;
  cmd_t push_cmd, head_cmd;

  mpsm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (full)
  );

  mpsm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd)
  );

  mpsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

### sv/mpsm_checker.sv
// ----------------------------------------------------------------------------
// mpsm_checker
// Port-level checks for the matcher core, bound to the top level.
// ----------------------------------------------------------------------------
module mpsm_checker import mpsm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // No result is shown in the cycle after a reset cycle
  a_rst_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

  // Every result names a tagged, non-root node
  a_out_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.pattern_tag != '0) && (out_item_o.match_node != '0))
    else $error("result with empty tag or root node");

  // A result never rises straight out of reset
  a_first_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rst_ni))
    else $error("result right out of reset");

  // An accepted input transaction carries a fully known payload
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> !$isunknown(in_item_i))
    else $error("input transaction accepted with unknown payload");

endmodule

bind multi_pattern_string_matcher_core mpsm_checker u_mpsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-pattern string matcher core. Loads small
// automata through table-write transactions, streams symbols along known
// edges and checks every reported match against a local automaton predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import mpsm_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  multi_pattern_string_matcher_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Automaton predictor, advanced on every accepted input transaction.
  // Every 7-bit node code is below NODE_COUNT, so stored nodes need no clamp.
  logic [ID_W-1:0]  auto_next [TT_DEPTH];
  logic [TAG_W-1:0] auto_tag  [NODE_COUNT];
  logic [ID_W-1:0]  auto_link [NODE_COUNT];
  logic [ID_W-1:0]  auto_node = '0;
  out_item_t        expected_matches[$];

  // Stimulus planning: tracks which table entries are loaded so that no
  // symbol ever reads an unwritten transition or node entry.
  logic [ID_W-1:0]  plan_next [TT_DEPTH];
  bit               plan_set  [TT_DEPTH];
  bit               plan_known[NODE_COUNT];
  int               known_nodes[$];
  logic [ID_W-1:0]  plan_node = '0;
  in_item_t         pending_items[$];

  int        gap_left = 0;
  int        in_quiet = 0;
  int        out_stall = 0;
  int        out_quiet = 0;
  int        item_total = 0;
  int        symbol_count = 0;
  int        match_count = 0;
  int        err_count = 0;
  out_item_t want;

  function automatic void step_automaton(in_item_t it);
    out_item_t       hits[$];
    out_item_t       hit;
    logic [ID_W-1:0] walk;
    case (it.func)
      FUNC_WR_TRANS: begin
        auto_next[int'(it.node) * ALPHABET_SIZE + int'(it.symbol)] = it.next_node;
      end
      FUNC_WR_NODE: begin
        auto_tag[it.node]  = it.tag;
        auto_link[it.node] = it.output_link;
      end
      FUNC_RESTART: begin
        auto_node = '0;
      end
      default: begin
        symbol_count++;
        auto_node = auto_next[int'(auto_node) * ALPHABET_SIZE + int'(it.symbol)];
        walk = auto_node;
        // Stop at the root, after MAX_CHAIN visits or at the result cap.
        for (int v = 0; v < MAX_CHAIN && walk != '0 && hits.size() < RESULT_LIMIT; v++) begin
          if (auto_tag[walk] != '0) begin
            hit.pattern_tag = auto_tag[walk];
            hit.match_node  = walk;
            hit.is_last     = 1'b0;
            hits.push_back(hit);
          end
          walk = auto_link[walk];
        end
        if (hits.size() != 0) hits[hits.size() - 1].is_last = 1'b1;
        foreach (hits[i]) expected_matches.push_back(hits[i]);
      end
    endcase
  endfunction

  function automatic void queue_item(in_item_t it);
    int a;
    a = int'(it.node) * ALPHABET_SIZE + int'(it.symbol);
    case (it.func)
      FUNC_WR_TRANS: begin
        plan_next[a] = it.next_node;
        plan_set[a]  = 1'b1;
      end
      FUNC_WR_NODE: begin
        if (!plan_known[it.node]) begin
          plan_known[it.node] = 1'b1;
          known_nodes.push_back(int'(it.node));
        end
      end
      FUNC_MATCH: begin
        plan_node = plan_next[int'(plan_node) * ALPHABET_SIZE + int'(it.symbol)];
      end
      default: begin
        plan_node = '0;
      end
    endcase
    pending_items.push_back(it);
  endfunction

  // Random content everywhere, so fields a function ignores still toggle.
  function automatic in_item_t noise_item(func_e f);
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.func = f;
    return it;
  endfunction

  function automatic void put_node(int n, int tg, int lk);
    in_item_t it;
    it = noise_item(FUNC_WR_NODE);
    it.node        = ID_W'(n);
    it.tag         = TAG_W'(tg);
    it.output_link = ID_W'(lk);
    queue_item(it);
  endfunction

  function automatic void put_edge(int n, int s, int nx);
    in_item_t it;
    it = noise_item(FUNC_WR_TRANS);
    it.node      = ID_W'(n);
    it.symbol    = ID_W'(s);
    it.next_node = ID_W'(nx);
    queue_item(it);
  endfunction

  function automatic void put_symbol(int s);
    in_item_t it;
    it = noise_item(FUNC_MATCH);
    it.symbol = ID_W'(s);
    queue_item(it);
  endfunction

  function automatic void put_restart();
    queue_item(noise_item(FUNC_RESTART));
  endfunction

  function automatic int any_known();
    return known_nodes[$urandom_range(0, known_nodes.size() - 1)];
  endfunction

  function automatic void random_item();
    int roll;
    int n;
    int sym;
    int tg;
    int opts[$];
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      for (int s = 0; s < ALPHABET_SIZE; s++)
        if (plan_set[int'(plan_node) * ALPHABET_SIZE + s]) opts.push_back(s);
      if (opts.size() == 0 || roll < 6) begin
        // Grow a fresh edge out of the current node, then follow it.
        sym = $urandom_range(0, ALPHABET_SIZE - 1);
        put_edge(plan_node, sym, any_known());
        put_symbol(sym);
      end else begin
        put_symbol(opts[$urandom_range(0, opts.size() - 1)]);
      end
    end else if (roll < 75) begin
      n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, NODE_COUNT - 1) : any_known();
      put_edge(n, $urandom_range(0, ALPHABET_SIZE - 1), any_known());
    end else if (roll < 91) begin
      n = ($urandom_range(0, 1) == 0) ? any_known() : $urandom_range(0, NODE_COUNT - 1);
      roll = $urandom_range(0, 9);
      tg = (roll < 3) ? 0 : (roll == 3) ? 255 : $urandom_range(1, 255);
      put_node(n, tg, ($urandom_range(0, 4) == 0) ? n : any_known());
    end else begin
      put_restart();
    end
  endfunction

  // Idle length per transaction, with occasional stretches of no idling.
  function automatic int draw_gap(ref int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) quiet = $urandom_range(8, 30);
    return $urandom_range(0, 15);
  endfunction

  function automatic void check_field(string what, logic [TAG_W-1:0] exp_v,
                                      logic [TAG_W-1:0] got_v);
    if (got_v !== exp_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endfunction

  // Input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item_total++;
        step_automaton(in_item);
      end
      // Hold the transaction until it is taken.
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_gap(in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        match_count++;
        if (expected_matches.size() == 0) begin
          err_count++;
          $display("%0t: unexpected match: expected none, got tag %0d node %0d last %0b",
                   $time, out_item.pattern_tag, out_item.match_node, out_item.is_last);
        end else begin
          want = expected_matches.pop_front();
          check_field("pattern_tag", want.pattern_tag, out_item.pattern_tag);
          check_field("match_node", want.match_node, out_item.match_node);
          check_field("is_last", want.is_last, out_item.is_last);
        end
        out_stall = draw_gap(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int directed_n;
    // Root tag is loaded but must never be reported.
    put_node(0, 255, 0);
    put_node(127, 255, 0);
    put_node(1, 1, 127);
    put_node(2, 0, 1);
    put_edge(0, 0, 2);
    put_edge(0, 127, 127);
    put_edge(2, 127, 1);
    put_symbol(0);
    put_symbol(127);
    put_restart();
    put_symbol(127);
    put_edge(127, 0, 0);
    put_symbol(0);
    // Two-node cycle: the walk reaches the visit cap and the result cap together.
    put_node(4, 4, 0);
    put_node(3, 3, 4);
    put_node(4, 4, 3);
    put_edge(0, 5, 3);
    put_symbol(5);
    // Untagged node with no link: a symbol with no match.
    put_node(5, 0, 0);
    put_edge(3, 1, 5);
    put_symbol(1);
    // Untagged head in front of the cycle: the visit cap cuts first.
    put_node(6, 0, 3);
    put_edge(5, 2, 6);
    put_symbol(2);
    put_restart();
    directed_n = pending_items.size();
    while (pending_items.size() < directed_n + 150) random_item();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(negedge clk_i);
    while (expected_matches.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Run covered %0d input transactions (%0d symbols) and %0d reported matches.",
             item_total, symbol_count, match_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d matches outstanding", expected_matches.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
sv/mpsm_pkg.sv
sv/mpsm_front.sv
sv/mpsm_queue.sv
sv/mpsm_back.sv
sv/multi_pattern_string_matcher_core.sv
sv/mpsm_checker.sv
bench/tb_top.sv
